[rtl/sln_pkg.sv]
// shared types, constants and helpers for the segment listing scanner
`default_nettype none

package sln_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned VALUE_W    = 20;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned PROD_W     = VALUE_W + 4;
   localparam int unsigned SUFFIX_LEN = 4;

   localparam int unsigned DIGIT_COUNT_DEFAULT = 6;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 20'hFFFFF;
   localparam logic [POS_W-1:0]   POS_MAX   = 4'd15;

   localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_L    = 8'h6C;
   localparam logic [BYTE_W-1:0] CHAR_O    = 8'h6F;
   localparam logic [BYTE_W-1:0] CHAR_G    = 8'h67;

   // result of one listing, handed from the scanner to the output register
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] next_number;
      logic               found_any;
   } result_type;

   // expected character of the ".log" suffix at a given offset
   function automatic logic [BYTE_W-1:0] suffix_char(input logic [1:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         2'd0:    ch = CHAR_DOT;
         2'd1:    ch = CHAR_L;
         2'd2:    ch = CHAR_O;
         default: ch = CHAR_G;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[rtl/segment_listing_next_number_core.sv]
// top level of the segment listing scanner
`default_nettype none

// Scans a directory listing one byte per request, names separated by NUL
// bytes, and on the request marked last returns the highest segment number
// (DIGIT_COUNT digits followed by ".log") plus one, or 0 with found_any low
// if there was none; the block then clears for the next listing. A final
// name not closed by a NUL is ignored. One request is taken every cycle; a
// result is offered by the result register once its last request has left
// the input register. The only stall is from the single result register: a
// last request waits in the input register until the previous result is taken.
module segment_listing_next_number_core
   import sln_pkg::*;
#(
   parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [BYTE_W-1:0]  req_listing_byte,
   input  wire logic               req_last_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [VALUE_W-1:0]      rsp_next_number,
   output logic                    rsp_found_any
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic              in_last_ff,  in_last_in;
   logic              fire;
   logic              out_free;
   result_type        result;

   always_comb begin
      // a last request needs room in the result register
      fire        = in_valid_ff && (!in_last_ff || out_free);
      req_ready   = !in_valid_ff || fire;
      in_valid_in = in_valid_ff && !fire;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_listing_byte;
         in_last_in  = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   sln_scan #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .listing_byte (in_byte_ff),
      .last_byte    (in_last_ff),
      .result       (result)
   );

   sln_out_reg u_out_reg (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_number (rsp_next_number),
      .rsp_found_any   (rsp_found_any)
   );

endmodule

`default_nettype wire

[rtl/sln_scan.sv]
// name scanner: per-byte state update and end-of-listing result
`default_nettype none

module sln_scan
   import sln_pkg::*;
#(
   parameter int unsigned DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [BYTE_W-1:0] listing_byte,
   input  wire logic              last_byte,
   output result_type             result
);

   localparam logic [POS_W-1:0] DIGIT_POS = POS_W'(DIGIT_COUNT);
   localparam logic [POS_W-1:0] END_POS   = POS_W'(DIGIT_COUNT + SUFFIX_LEN);

   logic [POS_W-1:0]   pos_ff,     pos_in;
   logic               still_ff,   still_in;
   logic [VALUE_W-1:0] value_ff,   value_in;
   logic [VALUE_W-1:0] highest_ff, highest_in;
   logic               any_ff,     any_in;

   logic [POS_W-1:0]   pos_upd;
   logic               still_upd;
   logic [VALUE_W-1:0] value_upd;
   logic [VALUE_W-1:0] highest_upd;
   logic               any_upd;
   logic               end_hit;
   logic               digit_ok;
   logic [PROD_W-1:0]  prod;
   logic [1:0]         suffix_off;

   always_comb begin
      digit_ok   = (listing_byte >= CHAR_ZERO) && (listing_byte <= CHAR_NINE);
      // value * 10 + digit, never overflows the wider product
      prod       = ({4'd0, value_ff} << 3) + ({4'd0, value_ff} << 1)
                   + PROD_W'(listing_byte[3:0]);
      suffix_off = 2'(pos_ff - DIGIT_POS);
      end_hit    = still_ff && (pos_ff == END_POS);

      pos_upd     = pos_ff;
      still_upd   = still_ff;
      value_upd   = value_ff;
      highest_upd = highest_ff;
      any_upd     = any_ff;

      if (listing_byte == CHAR_NUL) begin
         if (end_hit && (!any_ff || value_ff > highest_ff)) begin
            highest_upd = value_ff;
         end
         any_upd   = any_ff | end_hit;
         pos_upd   = '0;
         still_upd = 1'b1;
         value_upd = '0;
      end else begin
         if (still_ff) begin
            if (pos_ff < DIGIT_POS) begin
               if (digit_ok) begin
                  value_upd = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];
               end else begin
                  still_upd = 1'b0;
               end
            end else if (pos_ff < END_POS) begin
               if (listing_byte != suffix_char(suffix_off)) begin
                  still_upd = 1'b0;
               end
            end else begin
               still_upd = 1'b0;
            end
         end
         if (pos_ff < POS_MAX) begin
            pos_upd = pos_ff + POS_W'(1);
         end
      end

      result.valid       = fire && last_byte;
      result.found_any   = any_upd;
      result.next_number = '0;
      if (any_upd) begin
         result.next_number = (highest_upd >= VALUE_MAX) ? VALUE_MAX
                                                         : highest_upd + VALUE_W'(1);
      end

      pos_in     = pos_ff;
      still_in   = still_ff;
      value_in   = value_ff;
      highest_in = highest_ff;
      any_in     = any_ff;
      if (fire) begin
         if (last_byte) begin
            // listing done, start over
            pos_in     = '0;
            still_in   = 1'b1;
            value_in   = '0;
            highest_in = '0;
            any_in     = 1'b0;
         end else begin
            pos_in     = pos_upd;
            still_in   = still_upd;
            value_in   = value_upd;
            highest_in = highest_upd;
            any_in     = any_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         still_ff   <= 1'b1;
         value_ff   <= '0;
         highest_ff <= '0;
         any_ff     <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         still_ff   <= still_in;
         value_ff   <= value_in;
         highest_ff <= highest_in;
         any_ff     <= any_in;
      end
   end

endmodule

`default_nettype wire

[rtl/sln_out_reg.sv]
// result output register with valid/ready handshake
`default_nettype none

module sln_out_reg
   import sln_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire result_type         result,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [VALUE_W-1:0]      rsp_next_number,
   output logic                    rsp_found_any
);

   logic               valid_ff,  valid_in;
   logic [VALUE_W-1:0] number_ff, number_in;
   logic               found_ff,  found_in;

   always_comb begin
      out_free  = !valid_ff || rsp_ready;
      valid_in  = valid_ff && !rsp_ready;
      number_in = number_ff;
      found_in  = found_ff;
      if (result.valid) begin
         valid_in  = 1'b1;
         number_in = result.next_number;
         found_in  = result.found_any;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      number_ff <= number_in;
      found_ff  <= found_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_next_number = number_ff;
   assign rsp_found_any   = found_ff;

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for the segment listing scanner: random listings checked against a predictor
`timescale 1ns / 1ps

module testbench
   import sln_pkg::*;
;

   localparam int unsigned DIGITS         = DIGIT_COUNT_DEFAULT;
   localparam int unsigned PHASE_BYTES    = 380;
   localparam int unsigned HOLD_CYCLES    = 500;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned TAIL_CYCLES    = 10;

   typedef struct {
      logic [VALUE_W-1:0] next_number;
      logic               found_any;
   } listing_result_type;

   // tracks the scan state of the listing and the results still owed by the block
   class segment_number_tracker;
      int unsigned        digit_count;
      logic [POS_W-1:0]   name_pos;
      bit                 name_ok;
      logic [VALUE_W-1:0] name_val;
      logic [VALUE_W-1:0] highest;
      bit                 any_found;
      logic [BYTE_W-1:0]  suffix[SUFFIX_LEN];
      listing_result_type expected_results[$];
      int unsigned        failures;

      function new(int unsigned digits);
         digit_count = digits;
         failures    = 0;
         suffix[0]   = CHAR_DOT;
         suffix[1]   = CHAR_L;
         suffix[2]   = CHAR_O;
         suffix[3]   = CHAR_G;
         clear_listing();
      endfunction

      function void clear_name();
         name_pos = '0;
         name_ok  = 1'b1;
         name_val = '0;
      endfunction

      function void clear_listing();
         clear_name();
         highest   = '0;
         any_found = 1'b0;
      endfunction

      function void note_request(logic [BYTE_W-1:0] ch, logic last);
         int unsigned        acc;
         listing_result_type res;
         if (ch == CHAR_NUL) begin
            if (name_ok && name_pos == digit_count + SUFFIX_LEN) begin
               if (!any_found || name_val > highest) highest = name_val;
               any_found = 1'b1;
            end
            clear_name();
         end else begin
            if (name_ok) begin
               if (name_pos < digit_count) begin
                  if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                     acc = 32'(name_val) * 10 + 32'(ch - CHAR_ZERO);
                     if (name_val > VALUE_MAX / 10 || acc > 32'(VALUE_MAX)) acc = 32'(VALUE_MAX);
                     name_val = acc[VALUE_W-1:0];
                  end else begin
                     name_ok = 1'b0;
                  end
               end else if (name_pos < digit_count + SUFFIX_LEN) begin
                  if (ch != suffix[name_pos - digit_count]) name_ok = 1'b0;
               end else begin
                  name_ok = 1'b0;
               end
            end
            if (name_pos != POS_MAX) name_pos++;
         end
         // a name not closed by a NUL before the last byte never counts
         if (last) begin
            res.found_any   = any_found;
            res.next_number = !any_found ? '0 :
                              (highest == VALUE_MAX ? VALUE_MAX : highest + 1'b1);
            expected_results.push_back(res);
            clear_listing();
         end
      endfunction

      function void check_result(logic [VALUE_W-1:0] next_number, logic found_any);
         listing_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result: next_number %0d found_any %0b", next_number, found_any);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (next_number !== want.next_number) begin
            $error("next_number: expected %0d, got %0d", want.next_number, next_number);
            failures++;
         end
         if (found_any !== want.found_any) begin
            $error("found_any: expected %0b, got %0b", want.found_any, found_any);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_listing_byte = '0;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VALUE_W-1:0] rsp_next_number;
   logic               rsp_found_any;

   segment_number_tracker tracker;
   logic [BYTE_W-1:0]     listing_bytes[$];
   int unsigned           req_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           bytes_sent = 0;
   int unsigned           quiet_cycles = 0;
   int unsigned           hold_count = 0;
   logic                  long_hold_armed = 1'b0;

   segment_listing_next_number_core #(
      .DIGIT_COUNT(DIGITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_listing_byte (req_listing_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_number  (rsp_next_number),
      .rsp_found_any    (rsp_found_any)
   );

   always #2 clock = ~clock;

   // receiver: random stalls, plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (long_hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_next_number, rsp_found_any);
         if (req_valid && req_ready) tracker.note_request(req_listing_byte, req_last_byte);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_byte(logic [BYTE_W-1:0] ch, logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_listing_byte <= ch;
      req_last_byte    <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_listing();
      foreach (listing_bytes[i]) send_byte(listing_bytes[i], i == listing_bytes.size() - 1);
   endtask

   // fill of zero means random digits
   task automatic append_digits(int unsigned count, logic [BYTE_W-1:0] fill);
      repeat (count)
         listing_bytes.push_back(fill != CHAR_NUL ? fill :
                                 CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
   endtask

   task automatic append_suffix();
      listing_bytes.push_back(CHAR_DOT);
      listing_bytes.push_back(CHAR_L);
      listing_bytes.push_back(CHAR_O);
      listing_bytes.push_back(CHAR_G);
   endtask

   task automatic append_segment();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      append_digits(DIGITS, pick == 0 ? CHAR_NINE : (pick == 1 ? CHAR_ZERO : CHAR_NUL));
      append_suffix();
   endtask

   task automatic build_random_listing();
      int unsigned kind;
      int unsigned spot;
      listing_bytes.delete();
      repeat ($urandom_range(0, 4)) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            append_segment();
         end else if (kind < 58) begin
            append_digits($urandom_range(1, DIGITS - 1), CHAR_NUL);
            append_suffix();
         end else if (kind < 66) begin
            append_digits($urandom_range(DIGITS + 1, DIGITS + 7), CHAR_NUL);
            append_suffix();
         end else if (kind < 74) begin
            append_segment();
            spot = listing_bytes.size() - 1 - $urandom_range(0, SUFFIX_LEN - 1);
            listing_bytes[spot] = BYTE_W'($urandom_range(1, 255));
         end else if (kind < 80) begin
            append_segment();
            spot = listing_bytes.size() - SUFFIX_LEN - 1 - $urandom_range(0, DIGITS - 1);
            listing_bytes[spot] = BYTE_W'($urandom_range(1, 255));
         end else if (kind < 88) begin
            // empty name: a bare NUL
         end else begin
            repeat ($urandom_range(1, 20)) listing_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         end
         listing_bytes.push_back(CHAR_NUL);
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         if (listing_bytes.size() == 0 || listing_bytes[$] != CHAR_NUL)
            listing_bytes.push_back(CHAR_NUL);
      end else if (kind < 85) begin
         append_segment();
      end else begin
         listing_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_for_results();
      do @(posedge clock); while (tracker.expected_results.size() != 0);
   endtask

   initial begin
      int unsigned phase_start;
      tracker = new(DIGITS);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // highest possible segment after an empty name, closed by a NUL on the last byte
      listing_bytes.delete();
      listing_bytes.push_back(CHAR_NUL);
      append_digits(DIGITS, CHAR_NINE);
      append_suffix();
      listing_bytes.push_back(CHAR_NUL);
      send_listing();
      // overlong name left unterminated at the last byte
      listing_bytes.delete();
      append_digits(DIGITS + 1, CHAR_ZERO + 8'd1);
      append_suffix();
      send_listing();
      // all-ones byte then NUL as last byte, nothing found
      listing_bytes.delete();
      listing_bytes.push_back(8'hFF);
      listing_bytes.push_back(CHAR_NUL);
      send_listing();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 64; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 64; end
            default: begin req_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if (phase == 0 && !long_hold_armed && bytes_sent - phase_start > PHASE_BYTES / 2)
               long_hold_armed <= 1'b1;
            build_random_listing();
            send_listing();
         end
         // sender pauses until the block has handed back everything
         if (phase != 3) begin
            req_valid <= 1'b0;
            wait_for_results();
         end
      end

      req_valid <= 1'b0;
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.expected_results.size() != 0) begin
         $error("%0d results never arrived", tracker.expected_results.size());
         tracker.failures++;
      end
      if (tracker.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sln_pkg.sv
rtl/sln_scan.sv
rtl/sln_out_reg.sv
rtl/segment_listing_next_number_core.sv
verif/testbench.sv
